FILE: src/spr_pkg.sv
`default_nettype none

package spr_pkg;

   localparam int ANGLE_W = 16;
   localparam int STEP_W  = 16;
   localparam int VEL_W   = 5;
   localparam int DELAY_W = 4;

   // reciprocal divide of |position| * 2^15 by the steps per revolution
   localparam int DIV_SHIFT  = 45;
   localparam int DIV_M_W    = 42;
   localparam int DIV_SPLIT  = 21;
   localparam int PROD_W     = 37;
   localparam int SUM_W      = 58;
   localparam int MAG_W      = 27;
   localparam int ANG_W      = 28;
   localparam int CMP_W      = 29;

   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_MIN = 2'd0,
      CSR_ANGLE_MAX = 2'd1
   } csr_index_type;

   typedef logic [ANGLE_W-1:0] angle_type;
   typedef logic [STEP_W-1:0]  steps_type;
   typedef logic [VEL_W-1:0]   vel_type;
   typedef logic [DELAY_W-1:0] delay_type;

   // command prepared at the input register
   typedef struct packed {
      logic      load;
      logic      zero;
      angle_type angle;
      steps_type steps;
   } cmd_item_type;

   // result of one ramp step
   typedef struct packed {
      logic      step;
      logic      dir;
      steps_type pos;
      angle_type cmd;
   } ramp_result_type;

endpackage

`default_nettype wire

FILE: src/spr_axis_state.sv
`default_nettype none

module spr_axis_state #(
   parameter int NUM_AXES  = 3,
   parameter int MAX_SPEED = 8,
   localparam int AxisW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [AxisW-1:0]          in_axis,
   input  spr_pkg::cmd_item_type     in_cmd,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [AxisW-1:0]          out_axis,
   output spr_pkg::ramp_result_type  out_res
);

   localparam logic signed [5:0] MaxVel = 6'(MAX_SPEED);

   spr_pkg::angle_type held_angle_ff [NUM_AXES];
   spr_pkg::steps_type held_steps_ff [NUM_AXES];
   spr_pkg::steps_type pos_ff        [NUM_AXES];
   spr_pkg::vel_type   vel_ff        [NUM_AXES];
   spr_pkg::delay_type delay_ff      [NUM_AXES];

   logic                     out_valid_ff, out_valid_in;
   logic [AxisW-1:0]         out_axis_ff;
   spr_pkg::ramp_result_type out_res_ff, out_res_in;

   logic                in_range, fire;
   spr_pkg::angle_type  cur_angle, cmd_angle;
   spr_pkg::steps_type  cur_steps, cmd_steps, cur_pos, base_pos, next_pos;
   spr_pkg::vel_type    cur_vel, next_vel;
   spr_pkg::delay_type  cur_delay, next_delay, vel_abs;
   logic signed [16:0]  err, vel_wide;
   logic signed [5:0]   vel_step, vel_clamp;
   logic                step, dir;

   assign in_range = {1'b0, in_axis} < (AxisW+1)'(NUM_AXES);
   assign in_ready = !out_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      cur_angle = '0;
      cur_steps = '0;
      cur_pos   = '0;
      cur_vel   = '0;
      cur_delay = '0;
      if (in_range) begin
         cur_angle = held_angle_ff[in_axis];
         cur_steps = held_steps_ff[in_axis];
         cur_pos   = pos_ff[in_axis];
         cur_vel   = vel_ff[in_axis];
         cur_delay = delay_ff[in_axis];
      end

      cmd_angle = in_cmd.load ? in_cmd.angle : cur_angle;
      cmd_steps = in_cmd.load ? in_cmd.steps : cur_steps;
      base_pos  = in_cmd.zero ? '0 : cur_pos;

      // velocity moves one unit toward the position error
      err      = 17'($signed(cmd_steps)) - 17'($signed(base_pos));
      vel_wide = 17'($signed(cur_vel));
      vel_step = 6'($signed(cur_vel));
      if (vel_wide < err) begin
         vel_step = vel_step + 6'sd1;
      end else if (vel_wide > err) begin
         vel_step = vel_step - 6'sd1;
      end
      if (vel_step > MaxVel) begin
         vel_clamp = MaxVel;
      end else if (vel_step < -MaxVel) begin
         vel_clamp = -MaxVel;
      end else begin
         vel_clamp = vel_step;
      end
      vel_abs = vel_clamp[5] ? spr_pkg::delay_type'(-vel_clamp)
                             : spr_pkg::delay_type'(vel_clamp);

      if (cur_delay != '0) begin
         next_delay = cur_delay - spr_pkg::delay_type'(1);
         next_vel   = cur_vel;
         next_pos   = base_pos;
         step       = 1'b0;
         dir        = 1'b0;
      end else begin
         next_vel   = spr_pkg::vel_type'(vel_clamp);
         // a stopped axis gets no delay
         next_delay = (vel_clamp == 6'sd0) ? '0
                                           : spr_pkg::delay_type'(MAX_SPEED) - vel_abs;
         if (vel_clamp > 6'sd0) begin
            next_pos = base_pos + spr_pkg::steps_type'(1);
         end else if (vel_clamp < 6'sd0) begin
            next_pos = base_pos - spr_pkg::steps_type'(1);
         end else begin
            next_pos = base_pos;
         end
         step = (vel_clamp != 6'sd0);
         dir  = !vel_clamp[5];
      end

      if (in_range) begin
         out_res_in.step = step;
         out_res_in.dir  = dir;
         out_res_in.pos  = next_pos;
         out_res_in.cmd  = cmd_angle;
      end else begin
         out_res_in = '0;
      end

      out_valid_in = in_valid || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            held_angle_ff[i] <= '0;
            held_steps_ff[i] <= '0;
            pos_ff[i]        <= '0;
            vel_ff[i]        <= '0;
            delay_ff[i]      <= '0;
         end
      end else begin
         if (in_ready) begin
            out_valid_ff <= out_valid_in;
         end
         if (fire && in_range) begin
            held_angle_ff[in_axis] <= cmd_angle;
            held_steps_ff[in_axis] <= cmd_steps;
            pos_ff[in_axis]        <= next_pos;
            vel_ff[in_axis]        <= next_vel;
            delay_ff[in_axis]      <= next_delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_axis_ff <= in_axis;
         out_res_ff  <= out_res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_axis  = out_axis_ff;
   assign out_res   = out_res_ff;

endmodule

`default_nettype wire

FILE: src/spr_angle_conv.sv
`default_nettype none

module spr_angle_conv #(
   parameter int NUM_AXES      = 3,
   parameter int STEPS_PER_REV = 1600,
   localparam int AxisW        = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [AxisW-1:0]          in_axis,
   input  spr_pkg::ramp_result_type  in_res,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [AxisW-1:0]          out_axis,
   output logic                      out_step,
   output logic                      out_dir,
   output logic [15:0]               out_angle,
   output logic [15:0]               out_cmd
);

   localparam logic [63:0] DivM64 =
      ((64'd1 << spr_pkg::DIV_SHIFT) + 64'(STEPS_PER_REV) - 64'd1) / 64'(STEPS_PER_REV);
   localparam logic [spr_pkg::DIV_M_W-1:0] DivM = spr_pkg::DIV_M_W'(DivM64);
   localparam logic [spr_pkg::DIV_SPLIT-1:0] DivMLo = DivM[spr_pkg::DIV_SPLIT-1:0];
   localparam logic [spr_pkg::DIV_M_W-spr_pkg::DIV_SPLIT-1:0] DivMHi =
      DivM[spr_pkg::DIV_M_W-1:spr_pkg::DIV_SPLIT];
   localparam int MagLsb  = spr_pkg::DIV_SHIFT - 15;
   localparam int SnapTol = 32767 / STEPS_PER_REV + 1;

   // product stage
   logic                        mul_valid_ff, mul_valid_in, mul_ready;
   logic [AxisW-1:0]            mul_axis_ff;
   logic                        mul_step_ff, mul_dir_ff, mul_neg_ff;
   logic [15:0]                 mul_cmd_ff;
   logic [spr_pkg::PROD_W-1:0]  prod_lo_ff, prod_hi_ff, prod_lo_in, prod_hi_in;
   logic [15:0]                 pos_abs;

   // output stage
   logic                        out_valid_ff, out_valid_in;
   logic [AxisW-1:0]            out_axis_ff;
   logic                        out_step_ff, out_dir_ff;
   logic [15:0]                 out_angle_ff, out_angle_in, out_cmd_ff;

   logic [spr_pkg::SUM_W-1:0]   sum;
   logic [spr_pkg::MAG_W-1:0]   mag;
   logic signed [spr_pkg::ANG_W-1:0] ang;
   logic signed [spr_pkg::CMP_W-1:0] ang_w, cmd_w;
   logic                        snap;

   assign mul_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   always_comb begin
      pos_abs      = in_res.pos[15] ? (16'd0 - in_res.pos) : in_res.pos;
      prod_lo_in   = spr_pkg::PROD_W'(pos_abs) * spr_pkg::PROD_W'(DivMLo);
      prod_hi_in   = spr_pkg::PROD_W'(pos_abs) * spr_pkg::PROD_W'(DivMHi);
      mul_valid_in = in_valid || (mul_valid_ff && !mul_ready);
   end

   always_comb begin
      sum   = {prod_hi_ff, {spr_pkg::DIV_SPLIT{1'b0}}} + spr_pkg::SUM_W'(prod_lo_ff);
      mag   = sum[MagLsb +: spr_pkg::MAG_W];
      ang   = mul_neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      ang_w = spr_pkg::CMP_W'(ang);
      cmd_w = spr_pkg::CMP_W'($signed(mul_cmd_ff));
      // snap to the command when within tolerance
      snap  = (ang_w + spr_pkg::CMP_W'(SnapTol) > cmd_w) &&
              (ang_w - spr_pkg::CMP_W'(SnapTol) < cmd_w);
      out_angle_in = snap ? mul_cmd_ff : ang[15:0];
      out_valid_in = mul_valid_ff || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mul_valid_ff <= mul_valid_in;
         end
         if (mul_ready) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mul_axis_ff <= in_axis;
         mul_step_ff <= in_res.step;
         mul_dir_ff  <= in_res.dir;
         mul_neg_ff  <= in_res.pos[15];
         mul_cmd_ff  <= in_res.cmd;
         prod_lo_ff  <= prod_lo_in;
         prod_hi_ff  <= prod_hi_in;
      end
      if (mul_valid_ff && mul_ready) begin
         out_axis_ff  <= mul_axis_ff;
         out_step_ff  <= mul_step_ff;
         out_dir_ff   <= mul_dir_ff;
         out_angle_ff <= out_angle_in;
         out_cmd_ff   <= mul_cmd_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_axis  = out_axis_ff;
   assign out_step  = out_step_ff;
   assign out_dir   = out_dir_ff;
   assign out_angle = out_angle_ff;
   assign out_cmd   = out_cmd_ff;

endmodule

`default_nettype wire

FILE: src/stepper_position_ramp_unit.sv
// Trapezoidal ramp position controller for up to NUM_AXES stepper axes. Each
// request transaction is one drive tick for one axis: an optional new command
// angle (Q15 revolution, clamped to the limit registers), an optional clear of
// the position, then one ramp step that may issue a step pulse. The response
// carries the pulse, the direction, the position as a Q15 angle (snapped to
// the command within tolerance) and the held command. The unit is a four stage
// pipeline: input register with clamp and steps multiply, per-axis state
// read-modify-write, reciprocal multiply, and output register with the snap.
// It takes one transaction per clock when the response side is not stalled; a
// response passes the input, state, product and output registers in turn. The
// per-axis state update in the state stage lets ticks of an axis run back to back.
// Limit registers (index 0 min, index 1 max) are written whenever the csr port
// is valid and must only change while no transaction is in flight. A tick on
// an axis index at or above NUM_AXES changes nothing and returns zeros.
`default_nettype none

module stepper_position_ramp_unit #(
   parameter int NUM_AXES      = 3,
   parameter int MAX_SPEED     = 8,
   parameter int STEPS_PER_REV = 1600,
   localparam int AxisW        = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,

   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [AxisW-1:0]              req_axis_index,
   input  logic                          req_load_command,
   input  logic signed [15:0]            req_target_angle,
   input  logic                          req_zero_position,

   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [AxisW-1:0]              rsp_axis_out,
   output logic                          rsp_step_pulse,
   output logic                          rsp_step_direction,
   output logic signed [15:0]            rsp_position_angle,
   output logic signed [15:0]            rsp_command_angle_out,

   // limit register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);

   // limit registers
   logic signed [15:0] angle_min_ff, angle_max_ff;

   // input register stage
   logic                  s1_valid_ff, s1_valid_in, s1_ready;
   logic [AxisW-1:0]      s1_axis_ff;
   spr_pkg::cmd_item_type s1_cmd_ff, s1_cmd_in;

   logic signed [15:0]    clamped;
   logic signed [31:0]    steps_prod;

   // state stage to angle stage
   logic                     st_valid, st_ready;
   logic [AxisW-1:0]         st_axis;
   spr_pkg::ramp_result_type st_res;

   logic                  angle_ready;
   logic [15:0]           out_angle, out_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_min_ff <= -16'sd32768;
         angle_max_ff <= 16'sd32767;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spr_pkg::CSR_ANGLE_MIN: angle_min_ff <= $signed(csr_data);
            spr_pkg::CSR_ANGLE_MAX: angle_max_ff <= $signed(csr_data);
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // clamp against max first, then min; the order settles crossed limits
   always_comb begin
      if (req_target_angle >= angle_max_ff) begin
         clamped = angle_max_ff;
      end else if (req_target_angle <= angle_min_ff) begin
         clamped = angle_min_ff;
      end else begin
         clamped = req_target_angle;
      end
      // angle * steps per rev, arithmetic shift by 15, kept to 16 bits
      steps_prod = 32'(clamped) * $signed(32'(STEPS_PER_REV));
      s1_cmd_in.load  = req_load_command;
      s1_cmd_in.zero  = req_zero_position;
      s1_cmd_in.angle = clamped;
      s1_cmd_in.steps = steps_prod[30:15];
      s1_valid_in     = req_valid || (s1_valid_ff && !st_ready);
   end

   assign s1_ready  = !s1_valid_ff || st_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_axis_ff <= req_axis_index;
         s1_cmd_ff  <= s1_cmd_in;
      end
   end

   // per-axis state and ramp step
   spr_axis_state #(
      .NUM_AXES  (NUM_AXES),
      .MAX_SPEED (MAX_SPEED)
   ) u_axis_state (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (st_ready),
      .in_axis   (s1_axis_ff),
      .in_cmd    (s1_cmd_ff),
      .out_valid (st_valid),
      .out_ready (angle_ready),
      .out_axis  (st_axis),
      .out_res   (st_res)
   );

   // steps to Q15 angle and output register
   spr_angle_conv #(
      .NUM_AXES      (NUM_AXES),
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_angle_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid),
      .in_ready  (angle_ready),
      .in_axis   (st_axis),
      .in_res    (st_res),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_axis  (rsp_axis_out),
      .out_step  (rsp_step_pulse),
      .out_dir   (rsp_step_direction),
      .out_angle (out_angle),
      .out_cmd   (out_cmd)
   );

   assign rsp_position_angle    = $signed(out_angle);
   assign rsp_command_angle_out = $signed(out_cmd);

endmodule

`default_nettype wire

FILE: src/spr_checker.sv
`default_nettype none

module spr_checker #(
   parameter int NUM_AXES = 3,
   localparam int AxisW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [AxisW-1:0]              rsp_axis_out,
   input logic                          rsp_step_pulse,
   input logic                          rsp_step_direction,
   input logic signed [15:0]            rsp_position_angle,
   input logic signed [15:0]            rsp_command_angle_out,
   input logic                          csr_ready
);

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // ticks on absent axes report all zeros
   a_bad_axis_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ({1'b0, rsp_axis_out} >= (AxisW+1)'(NUM_AXES))) |->
      (!rsp_step_pulse && !rsp_step_direction &&
       rsp_position_angle == 16'sd0 && rsp_command_angle_out == 16'sd0))
      else $error("nonzero response for absent axis");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_axis_out) && $stable(rsp_step_pulse) &&
       $stable(rsp_position_angle) && $stable(rsp_command_angle_out)))
      else $error("stalled response changed");

   // with an empty pipeline a request is never stalled
   a_idle_accepts: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!req_valid) && $past(!req_valid, 2) &&
       $past(!req_valid, 3) && $past(!rsp_valid)) |-> (!req_stall && csr_ready))
      else $error("request stalled while pipeline empty");

endmodule

bind stepper_position_ramp_unit spr_checker #(
   .NUM_AXES (NUM_AXES)
) u_spr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_axis_out          (rsp_axis_out),
   .rsp_step_pulse        (rsp_step_pulse),
   .rsp_step_direction    (rsp_step_direction),
   .rsp_position_angle    (rsp_position_angle),
   .rsp_command_angle_out (rsp_command_angle_out),
   .csr_ready             (csr_ready)
);

`default_nettype wire

FILE: tb/tb_stepper_position_ramp_unit.sv
module tb_stepper_position_ramp_unit;

   // block configuration under test
   localparam int NUM_AXES      = 3;
   localparam int MAX_SPEED     = 8;
   localparam int STEPS_PER_REV = 1600;
   // position angle snaps to the command inside this window
   localparam int SNAP_TOL      = 32767 / STEPS_PER_REV + 1;

   // run shape
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 8;       // pipeline is four deep
   localparam int HOLD_CYCLES    = 200;     // long response hold-off
   localparam int PRESSURE_AFTER = 300;     // responses seen before the hold-off
   localparam int TRAVEL_ITEMS   = 1700;    // full-revolution move on axis 0
   localparam int PHASE_ITEMS    = 50;
   localparam int NUM_PHASES     = 6;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MAX_ERR_PRINTS = 40;

   // csr indexes that the block has no register for
   localparam logic [spr_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [spr_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [1:0]         axis;
      logic               load;
      logic signed [15:0] target;
      logic               zero;
   } tick_type;

   typedef struct packed {
      logic [1:0]         axis;
      logic               step;
      logic               dir;
      logic signed [15:0] pos_angle;
      logic signed [15:0] cmd_angle;
   } ramp_result_type;

   typedef struct packed {
      tick_type        tick;
      logic            typed_in;   // 1: want holds the expected response
      ramp_result_type want;
   } directed_row_type;

   localparam int NUM_DIRECTED = 23;

   // directed ticks, default limits right after reset
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      // idle tick after reset, position snaps onto the zero command
      '{'{2'd0, 1'b0, 16'sd0, 1'b0}, 1'b1, '{2'd0, 1'b0, 1'b1, 16'sd0, 16'sd0}},
      // axis out of range, everything else zero
      '{'{2'd3, 1'b1, 16'sd32767, 1'b1}, 1'b1, '{2'd3, 1'b0, 1'b0, 16'sd0, 16'sd0}},
      // top command angle, first forward step
      '{'{2'd1, 1'b1, 16'sd32767, 1'b0}, 1'b1,
        '{2'd1, 1'b1, 1'b1, 16'sd20, 16'sd32767}},
      // bottom command angle, first reverse step
      '{'{2'd2, 1'b1, 16'sh8000, 1'b0}, 1'b1,
        '{2'd2, 1'b1, 1'b0, -16'sd20, 16'sh8000}},
      '{'{2'd3, 1'b1, 16'sh8000, 1'b0}, 1'b1, '{2'd3, 1'b0, 1'b0, 16'sd0, 16'sd0}},
      // delay countdown on axis 1
      '{'{2'd1, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd1, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd1, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd1, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd2, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      // position clear while the axis is moving
      '{'{2'd1, 1'b0, 16'sh5555, 1'b1}, 1'b0, '0},
      '{'{2'd0, 1'b1, 16'sd200, 1'b0}, 1'b0, '0},
      '{'{2'd0, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      // smallest negative angle rounds down to one step back
      '{'{2'd0, 1'b1, -16'sd1, 1'b0}, 1'b0, '0},
      '{'{2'd0, 1'b1, 16'shAAAA, 1'b1}, 1'b0, '0},
      '{'{2'd2, 1'b0, 16'sd0, 1'b1}, 1'b0, '0},
      // just outside and just inside the snap window
      '{'{2'd1, 1'b1, 16'sd21, 1'b1}, 1'b0, '0},
      '{'{2'd1, 1'b1, 16'sd20, 1'b0}, 1'b0, '0},
      '{'{2'd1, 1'b0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd2, 1'b1, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{2'd3, 1'b0, 16'sh5555, 1'b1}, 1'b1, '{2'd3, 1'b0, 1'b0, 16'sd0, 16'sd0}},
      '{'{2'd0, 1'b1, 16'sd32766, 1'b0}, 1'b0, '0},
      '{'{2'd0, 1'b0, 16'sd0, 1'b0}, 1'b0, '0}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_axis_index;
   logic                          req_load_command;
   logic signed [15:0]            req_target_angle;
   logic                          req_zero_position;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_axis_out;
   logic                          rsp_step_pulse;
   logic                          rsp_step_direction;
   logic signed [15:0]            rsp_position_angle;
   logic signed [15:0]            rsp_command_angle_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [spr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                   csr_data;

   // predictor copy of the limit registers and the per-axis store
   int clamp_lo;
   int clamp_hi;
   int cmd_q15    [NUM_AXES];
   int cmd_steps  [NUM_AXES];
   int pos_steps  [NUM_AXES];
   int speed      [NUM_AXES];
   int hold_count [NUM_AXES];

   ramp_result_type pending_ramp_results [$];

   int fails        = 0;
   int err_prints   = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int snd_quiet    = 0;
   int rcv_quiet    = 0;
   int cur_axis     = 0;

   stepper_position_ramp_unit #(
      .NUM_AXES      (NUM_AXES),
      .MAX_SPEED     (MAX_SPEED),
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_axis_index        (req_axis_index),
      .req_load_command      (req_load_command),
      .req_target_angle      (req_target_angle),
      .req_zero_position     (req_zero_position),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_axis_out          (rsp_axis_out),
      .rsp_step_pulse        (rsp_step_pulse),
      .rsp_step_direction    (rsp_step_direction),
      .rsp_position_angle    (rsp_position_angle),
      .rsp_command_angle_out (rsp_command_angle_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // keep the low 16 bits, sign extended
   function automatic int wrap16(int v);
      logic signed [15:0] w;
      w = v[15:0];
      return int'(w);
   endfunction

   // one drive tick on the predictor: clamp and load, clear, ramp step, angle
   function automatic ramp_result_type predict_ramp_tick(tick_type t);
      ramp_result_type r;
      int ax;
      int tgt;
      int err;
      int v;
      int ang;
      r = '0;
      r.axis = t.axis;
      ax = int'(t.axis);
      if (ax >= NUM_AXES) return r;
      if (t.load) begin
         tgt = int'(t.target);
         // the maximum is tested first, which also settles inverted limits
         if (tgt >= clamp_hi) tgt = clamp_hi;
         else if (tgt <= clamp_lo) tgt = clamp_lo;
         cmd_q15[ax] = tgt;
         cmd_steps[ax] = wrap16((tgt * STEPS_PER_REV) >>> 15);
      end
      if (t.zero) pos_steps[ax] = 0;
      if (hold_count[ax] > 0) begin
         hold_count[ax]--;
      end else begin
         err = cmd_steps[ax] - pos_steps[ax];
         v = speed[ax];
         if (v < err) v++;
         else if (v > err) v--;
         if (v > MAX_SPEED) v = MAX_SPEED;
         else if (v < -MAX_SPEED) v = -MAX_SPEED;
         speed[ax] = v;
         if (v > 0) begin
            pos_steps[ax] = wrap16(pos_steps[ax] + 1);
            hold_count[ax] = MAX_SPEED - v;
         end else if (v < 0) begin
            pos_steps[ax] = wrap16(pos_steps[ax] - 1);
            hold_count[ax] = MAX_SPEED + v;
         end else begin
            hold_count[ax] = 0;
         end
         r.step = (v != 0);
         r.dir = (v >= 0);
      end
      // truncating divide, then snap onto the command when close
      ang = (pos_steps[ax] * 32768) / STEPS_PER_REV;
      if ((ang + SNAP_TOL > cmd_q15[ax]) && (ang - SNAP_TOL < cmd_q15[ax]))
         ang = cmd_q15[ax];
      r.pos_angle = ang[15:0];
      r.cmd_angle = cmd_q15[ax][15:0];
      return r;
   endfunction

   // idle cycles before the next transaction, with runs of back-to-back ones
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // random tick; travel mode keeps axis 0 moving toward its far command
   function automatic tick_type draw_tick(bit travel);
      tick_type t;
      int ax;
      int tgt;
      int sel;
      t.target = 16'($urandom);
      if (travel) begin
         if ($urandom_range(0, 39) != 0) begin
            t.axis = 2'd0;
            t.load = 1'b0;
            t.zero = 1'b0;
         end else begin
            t.axis = 2'($urandom_range(1, 3));
            t.load = 1'($urandom_range(0, 1));
            t.zero = 1'($urandom_range(0, 1));
         end
         return t;
      end
      // axis sticks for a while so ramps get somewhere, sometimes out of range
      if ($urandom_range(0, 24) == 0) begin
         ax = 3;
      end else begin
         if ($urandom_range(0, 6) == 0) cur_axis = $urandom_range(0, NUM_AXES - 1);
         ax = cur_axis;
      end
      t.axis = 2'(ax);
      t.load = ($urandom_range(0, 99) < 25);
      t.zero = ($urandom_range(0, 99) < 4);
      if (t.load) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            // short move around the held command
            tgt = ((ax < NUM_AXES) ? cmd_q15[ax] : 0) + int'($urandom_range(0, 800)) - 400;
            if (tgt > 32767) tgt = 32767;
            else if (tgt < -32768) tgt = -32768;
            t.target = tgt[15:0];
         end else if (sel >= 80) begin
            case ($urandom_range(0, 3))
               0: t.target = 16'sd32767;
               1: t.target = 16'sh8000;
               2: t.target = clamp_lo[15:0];
               default: t.target = clamp_hi[15:0];
            endcase
         end
      end
      return t;
   endfunction

   // one request transaction, expectation queued when it is accepted
   task automatic send_tick(tick_type t, logic typed_in, ramp_result_type want);
      int gap;
      ramp_result_type pred;
      gap = draw_wait(snd_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_axis_index    <= t.axis;
      req_load_command  <= t.load;
      req_target_angle  <= t.target;
      req_zero_position <= t.zero;
      do @(posedge clock); while (req_stall);
      // predictor runs on every tick so the axis state stays in step
      pred = predict_ramp_tick(t);
      pending_ramp_results.push_back(typed_in ? want : pred);
   endtask

   // limit register write; valid stays up for back-to-back writes
   task automatic csr_write(logic [spr_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == spr_pkg::CSR_ANGLE_MIN) clamp_lo = int'($signed(data));
      else if (idx == spr_pkg::CSR_ANGLE_MAX) clamp_hi = int'($signed(data));
   endtask

   // all responses in, then let the pipeline settle
   task automatic wait_idle();
      while (pending_ramp_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         fails++;
         if (err_prints < MAX_ERR_PRINTS) begin
            err_prints++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
         end
      end
   endtask

   // response checker: each accepted transaction against the oldest expectation
   always @(posedge clock) begin : rsp_check
      ramp_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ramp_results.size() == 0) begin
            fails++;
            if (err_prints < MAX_ERR_PRINTS) begin
               err_prints++;
               $display("%0t: response transaction with nothing expected, axis %0d",
                        $time, rsp_axis_out);
            end
         end else begin
            e = pending_ramp_results.pop_front();
            check_field("axis_out", int'(e.axis), int'(rsp_axis_out));
            check_field("step_pulse", int'(e.step), int'(rsp_step_pulse));
            check_field("step_direction", int'(e.dir), int'(rsp_step_direction));
            check_field("position_angle", int'(e.pos_angle), int'(rsp_position_angle));
            check_field("command_angle_out", int'(e.cmd_angle),
                        int'(rsp_command_angle_out));
            results_seen++;
         end
      end
   end

   // response side: random stall per transaction, one long hold-off
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && results_seen >= PRESSURE_AFTER) begin
            // sender keeps going, so the pipeline fills and stalls the requests
            held = 1'b1;
            n = HOLD_CYCLES;
         end else begin
            n = draw_wait(rcv_quiet);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // stimulus: reset, directed table, then phases with different limits
   initial begin
      int i;
      int ph;
      int k;
      int n_items;
      logic [15:0] lo;
      logic [15:0] hi;
      req_valid         <= 1'b0;
      req_axis_index    <= '0;
      req_load_command  <= 1'b0;
      req_target_angle  <= '0;
      req_zero_position <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= '0;
      csr_data          <= '0;
      reset             <= 1'b1;
      // predictor state after reset
      clamp_lo = -32768;
      clamp_hi = 32767;
      for (i = 0; i < NUM_AXES; i++) begin
         cmd_q15[i]    = 0;
         cmd_steps[i]  = 0;
         pos_steps[i]  = 0;
         speed[i]      = 0;
         hold_count[i] = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++)
         send_tick(DIRECTED[i].tick, DIRECTED[i].typed_in, DIRECTED[i].want);
      req_valid <= 1'b0;

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         // limits only change with nothing in flight
         wait_idle();
         case (ph)
            0: begin
               lo = 16'h8000;
               hi = 16'h7fff;
            end
            1: begin
               lo = 16'h0000;
               hi = 16'h0000;
            end
            2: begin
               // inverted window
               lo = 16'd1000;
               hi = -16'sd1000;
            end
            3: begin
               lo = 16'h7fff;
               hi = 16'h8000;
            end
            4: begin
               lo = 16'($urandom);
               hi = 16'($urandom);
            end
            default: begin
               lo = 16'(-int'($urandom_range(0, 3000)));
               hi = 16'($urandom_range(0, 3000));
            end
         endcase
         csr_write(spr_pkg::CSR_ANGLE_MIN, lo);
         csr_write(spr_pkg::CSR_ANGLE_MAX, hi);
         // writes to indexes without a register change nothing
         if (ph == 0 || ph == NUM_PHASES - 1) begin
            csr_write(CSR_SPARE_A, 16'($urandom));
            csr_write(CSR_SPARE_B, 16'($urandom));
         end
         csr_valid <= 1'b0;

         if (ph == 0) begin
            // full ramp from zero to the top command, just short of one turn
            send_tick('{2'd0, 1'b1, 16'sd32767, 1'b1}, 1'b0, '0);
            n_items = TRAVEL_ITEMS;
         end else begin
            n_items = PHASE_ITEMS;
         end
         for (k = 0; k < n_items; k++)
            send_tick(draw_tick(ph == 0), 1'b0, '0);
         req_valid <= 1'b0;
      end

      wait_idle();
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: stepper_position_ramp_unit.f
src/spr_pkg.sv
src/spr_axis_state.sv
src/spr_angle_conv.sv
src/stepper_position_ramp_unit.sv
src/spr_checker.sv
tb/tb_stepper_position_ramp_unit.sv
